@@ rtl/core/cft_pkg.sv @@
// Shared types, character codes and helper functions of the CSV field tokenizer.
package cft_pkg;

  // Character codes
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Widths fixed by the stream fields
  localparam int unsigned COL_W   = 6;
  localparam int unsigned COUNT_W = 7;

  // Largest column count the tokenizer supports
  localparam int unsigned MAX_COLUMNS = 64;

  // Default queue depth between front and back end
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Column count after reset
  localparam logic [COUNT_W-1:0] COLUMN_COUNT_RST = 7'd1;

  // Parser mode of the front end
  typedef enum logic [3:0] {
    MODE_START  = 4'b0001,
    MODE_PLAIN  = 4'b0010,
    MODE_QUOTED = 4'b0100,
    MODE_QSEEN  = 4'b1000
  } mode_t;

  // Trailing word added for the last byte of the text
  typedef enum logic [1:0] {
    TAIL_NONE   = 2'd0,
    TAIL_FIELD  = 2'd1,
    TAIL_RECORD = 2'd2,
    TAIL_BARE   = 2'd3
  } tail_t;

  // One classified input byte: a run of field ends, an optional content byte,
  // an optional tail word
  typedef struct packed {
    logic [COUNT_W-1:0] n_ends;
    logic [COL_W-1:0]   start_col;
    logic               has_byte;
    logic [7:0]         data;
    logic [COL_W-1:0]   byte_col;
    tail_t              tail;
    logic [COL_W-1:0]   tail_col;
    logic               done;
  } cmd_t;

  // One result word
  typedef struct packed {
    logic [7:0]       data_byte;
    logic             has_byte;
    logic             ends_field;
    logic             ends_record;
    logic [COL_W-1:0] column_index;
    logic             input_done;
    logic             last_of_run;
  } res_t;

  // Clamp the configured column count into 1..MAX_COLUMNS
  function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] cc);
    logic [COUNT_W-1:0] n;
    n = cc;
    if (cc == '0) begin
      n = 7'd1;
    end else if (cc > COUNT_W'(MAX_COLUMNS)) begin
      n = COUNT_W'(MAX_COLUMNS);
    end
    return n;
  endfunction

  // True when a field ending in this column closes the record
  function automatic logic closes(input logic [COL_W-1:0] col,
                                  input logic [COUNT_W-1:0] eff);
    return ({1'b0, col} + 7'd1) >= eff;
  endfunction

  // Column after a field end
  function automatic logic [COL_W-1:0] next_col(input logic [COL_W-1:0] col,
                                                input logic [COUNT_W-1:0] eff);
    return closes(col, eff) ? '0 : col + 6'd1;
  endfunction

  // Number of field ends a line break emits from this column
  function automatic logic [COUNT_W-1:0] pad_count(input logic [COL_W-1:0] col,
                                                   input logic [COUNT_W-1:0] eff);
    return closes(col, eff) ? 7'd1 : eff - {1'b0, col};
  endfunction

  function automatic logic is_break(input logic [7:0] b);
    return (b == CH_CR) || (b == CH_LF);
  endfunction

endpackage

@@ rtl/core/cft_front.sv @@
// Front end: accepts text bytes, tracks the quoting state and column, and
// turns each byte into at most one command word.
module cft_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [cft_pkg::COUNT_W-1:0]   eff,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // text_byte
  input  logic                          s_tlast,   // final_byte
  input  logic                          q_full,
  output logic                          push,
  output cft_pkg::cmd_t                 push_cmd
);

  cft_pkg::mode_t                mode, mode_next;
  logic [cft_pkg::COL_W-1:0]     col, col_next;
  logic                          accept;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // Classify the byte against the current mode
  always_comb begin
    logic [cft_pkg::COUNT_W-1:0] n;
    logic [cft_pkg::COL_W-1:0]   c;
    cft_pkg::mode_t              m;
    logic                        emit_b;
    logic [cft_pkg::COL_W-1:0]   bcol;
    logic                        do_fs;
    cft_pkg::tail_t              tl;
    logic [cft_pkg::COL_W-1:0]   tcol;

    n      = '0;
    c      = col;
    m      = mode;
    emit_b = 1'b0;
    bcol   = col;
    do_fs  = 1'b0;
    tl     = cft_pkg::TAIL_NONE;
    tcol   = '0;

    unique case (mode)
      cft_pkg::MODE_START: begin
        do_fs = 1'b1;
      end
      cft_pkg::MODE_PLAIN: begin
        if (s_tdata == cft_pkg::CH_COMMA) begin
          n = 7'd1;
          c = cft_pkg::next_col(col, eff);
          m = cft_pkg::MODE_START;
        end else if (cft_pkg::is_break(s_tdata)) begin
          n = cft_pkg::pad_count(col, eff);
          c = '0;
          m = cft_pkg::MODE_START;
        end else begin
          emit_b = 1'b1;
        end
      end
      cft_pkg::MODE_QUOTED: begin
        if (s_tdata == cft_pkg::CH_QUOTE) begin
          m = cft_pkg::MODE_QSEEN;
        end else begin
          emit_b = 1'b1;
        end
      end
      cft_pkg::MODE_QSEEN: begin
        if (s_tdata == cft_pkg::CH_QUOTE) begin
          emit_b = 1'b1;
          m      = cft_pkg::MODE_QUOTED;
        end else begin
          // close the field; anything but a comma is then taken as the first byte of the next one
          n = 7'd1;
          c = cft_pkg::next_col(col, eff);
          m = cft_pkg::MODE_START;
          do_fs = (s_tdata != cft_pkg::CH_COMMA);
        end
      end
      default: begin
        m = cft_pkg::MODE_START;
      end
    endcase

    // First byte of a field
    if (do_fs) begin
      if (s_tdata == cft_pkg::CH_QUOTE) begin
        m = cft_pkg::MODE_QUOTED;
      end else if (s_tdata == cft_pkg::CH_COMMA) begin
        n = n + 7'd1;
        c = cft_pkg::next_col(c, eff);
        m = cft_pkg::MODE_START;
      end else if (cft_pkg::is_break(s_tdata)) begin
        if (c != '0) begin
          n = n + cft_pkg::pad_count(c, eff);
          c = '0;
        end
      end else begin
        emit_b = 1'b1;
        bcol   = c;
        m      = cft_pkg::MODE_PLAIN;
      end
    end

    // Close out the text on the final byte
    if (s_tlast) begin
      if (m != cft_pkg::MODE_START) begin
        tl   = cft_pkg::TAIL_FIELD;
        tcol = c;
      end else if (c != '0) begin
        tl   = cft_pkg::TAIL_RECORD;
        tcol = c;
      end else if ((n == '0) && !emit_b) begin
        tl = cft_pkg::TAIL_BARE;
      end
      m = cft_pkg::MODE_START;
      c = '0;
    end

    mode_next          = m;
    col_next           = c;
    push_cmd.n_ends    = n;
    push_cmd.start_col = col;
    push_cmd.has_byte  = emit_b;
    push_cmd.data      = s_tdata;
    push_cmd.byte_col  = bcol;
    push_cmd.tail      = tl;
    push_cmd.tail_col  = tcol;
    push_cmd.done      = s_tlast;
    push = accept && ((n != '0) || emit_b || s_tlast);
  end

  // Advance the parse state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= cft_pkg::MODE_START;
      col  <= '0;
    end else if (accept) begin
      mode <= mode_next;
      col  <= col_next;
    end
  end

endmodule

@@ rtl/core/cft_queue.sv @@
// Small command queue between the front end and the back end.
module cft_queue #(
  parameter int unsigned DEPTH = cft_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cft_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output cft_pkg::cmd_t head,
  output logic          empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cft_pkg::cmd_t    entries [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/cft_back.sv @@
// Back end: expands each command into result words and holds the output
// register.
module cft_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [cft_pkg::COUNT_W-1:0] eff,
  input  cft_pkg::cmd_t               head,
  input  logic                        empty,
  output logic                        pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,  // data_byte, column_index, zero pad
  output logic [3:0]                  m_tuser,  // has_byte, ends_field, ends_record,
                                                // input_done
  output logic                        m_tlast   // last_of_run
);

  logic [cft_pkg::COUNT_W-1:0] k;
  logic [cft_pkg::COL_W-1:0]   run_col;
  logic                        byte_done;
  logic [cft_pkg::COL_W-1:0]   col_now;
  logic                        in_ends;
  logic                        load;
  cft_pkg::res_t               res, out_res;

  assign col_now = (k == '0) ? head.start_col : run_col;
  assign in_ends = (k < head.n_ends);
  assign load    = !empty && (!m_tvalid || m_tready);
  assign pop     = load && res.last_of_run;

  // Build the next word of the command at the head of the queue
  always_comb begin
    res = '0;
    if (in_ends) begin
      res.ends_field   = 1'b1;
      res.ends_record  = cft_pkg::closes(col_now, eff);
      res.column_index = col_now;
      res.last_of_run  = ((k + 7'd1) == head.n_ends) && !head.has_byte &&
                         (head.tail == cft_pkg::TAIL_NONE);
    end else if (head.has_byte && !byte_done) begin
      res.data_byte    = head.data;
      res.has_byte     = 1'b1;
      res.column_index = head.byte_col;
      res.last_of_run  = (head.tail == cft_pkg::TAIL_NONE);
    end else begin
      res.column_index = head.tail_col;
      res.last_of_run  = 1'b1;
      unique case (head.tail)
        cft_pkg::TAIL_FIELD: begin
          res.ends_field  = 1'b1;
          res.ends_record = 1'b1;
        end
        cft_pkg::TAIL_RECORD: begin
          res.ends_record = 1'b1;
        end
        cft_pkg::TAIL_BARE,
        cft_pkg::TAIL_NONE: begin
          res.column_index = '0;
        end
      endcase
    end
    res.input_done = head.done && res.last_of_run;
  end

  // Step through the command
  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      byte_done <= 1'b0;
    end else if (load) begin
      if (res.last_of_run) begin
        k         <= '0;
        byte_done <= 1'b0;
      end else if (in_ends) begin
        k <= k + 7'd1;
      end else begin
        byte_done <= 1'b1;
      end
    end
  end

  // Track the column through a run of field ends
  always_ff @(posedge clk) begin
    if (load && in_ends) begin
      run_col <= cft_pkg::next_col(col_now, eff);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

  assign m_tdata = {2'b00, out_res.column_index, out_res.data_byte};
  assign m_tuser = {out_res.input_done, out_res.ends_record, out_res.ends_field,
                    out_res.has_byte};
  assign m_tlast = out_res.last_of_run;

endmodule

@@ rtl/core/csv_field_tokenizer_top.sv @@
// CSV field tokenizer: one text byte in per word, content bytes and field and
// record ends out, each tagged with its column. A byte that causes at most one
// result word passes through the command queue and the output register. While
// m_tready is high, plain text streams at one byte per clock and the back end
// gives one word per cycle. A line break that pads a short record, a byte
// after a closing quote or the final byte can cause a run of words and then
// hold the back end until all of them, up to column_count or to three when
// the count is below three, are out. The front end keeps accepting until the
// command queue of QUEUE_DEPTH entries is full. column_count may only be
// written while the block is idle; 0 acts as 1 and values above 64 act as 64.
module csv_field_tokenizer_top #(
  parameter int unsigned QUEUE_DEPTH = cft_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [6:0]  cfg_wdata,  // column_count
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // text_byte
  input  logic        s_tlast,    // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // data_byte[7:0], column_index[13:8], zero pad
  output logic [3:0]  m_tuser,    // has_byte, ends_field, ends_record, input_done
  output logic        m_tlast     // last_of_run
);

  logic [cft_pkg::COUNT_W-1:0] column_count;
  logic [cft_pkg::COUNT_W-1:0] eff;
  logic                        q_full, q_empty, push, pop;
  cft_pkg::cmd_t               push_cmd, head;

  // Hold the column count register
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= cft_pkg::COLUMN_COUNT_RST;
    end else if (cfg_wen) begin
      column_count <= cfg_wdata;
    end
  end

  assign eff = cft_pkg::eff_count(column_count);

  cft_front u_front (
    .clk      (clk),
    .rst      (rst),
    .eff      (eff),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  cft_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  cft_back u_back (
    .clk      (clk),
    .rst      (rst),
    .eff      (eff),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

@@ rtl/core/cft_checker.sv @@
// Port-level checks of the CSV field tokenizer, bound to the top level.
module cft_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [3:0]  m_tuser,
  input logic        m_tlast
);

  // No word comes out of reset
  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  // A stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("stalled output word changed");

  // A content word carries no end marks
  a_byte_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tuser[1] && !m_tuser[2] && !m_tuser[3])
    else $error("content word also marks an end");

  // End of input is always the last word of its byte
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3] |-> m_tlast)
    else $error("input done on a word that is not last of its run");

  // Pad bits of tdata stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[15:14] == 2'b00)
    else $error("tdata pad bits set");

endmodule

bind csv_field_tokenizer_top cft_checker u_cft_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
